// ----- sv/pwf_pkg.sv -----
// ----------------------------------------------------------------------------
// PID with feedforward: shared package
// Widths, register indexes, state and term codes, and the request and
// response bundles that pass between the controller and its serial units.
// ----------------------------------------------------------------------------
`default_nettype none

package pwf_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int DERIV_FRAC_BITS = 8;
  localparam int ELAPSED_W       = 16;
  localparam int GAIN_W          = 32;
  localparam int ILIM_W          = 31;
  localparam int OLIM_W          = 15;
  localparam int ERR_W           = SAMPLE_BITS + 1;
  localparam int DIFF_W          = SAMPLE_BITS + 2;
  // Divider dividend is |diff| shifted up by the derivative fraction bits.
  localparam int DIVN_W          = DIFF_W - 1 + DERIV_FRAC_BITS;
  localparam int MPLIER_W        = 32;
  localparam int PROD_W          = 64;
  localparam int CFG_IDX_W       = 8;
  localparam int CFG_DATA_W      = 32;
  localparam int GAIN_SHIFT      = 16;
  localparam int DERIV_SHIFT     = 16 + DERIV_FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT    = 8'd0,
    CFG_PROP_GAIN   = 8'd1,
    CFG_INTEG_GAIN  = 8'd2,
    CFG_DERIV_GAIN  = 8'd3,
    CFG_FF_GAIN     = 8'd4,
    CFG_INTEG_LIMIT = 8'd5,
    CFG_OUT_LIMIT   = 8'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INT_GO,
    ST_INT_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_TRM_GO,
    ST_TRM_WAIT,
    ST_SUM
  } state_e;

  typedef enum logic [1:0] {
    TERM_P = 2'd0,
    TERM_I = 2'd1,
    TERM_D = 2'd2,
    TERM_F = 2'd3
  } term_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sensor_value;
    logic [ELAPSED_W-1:0]          elapsed_ticks;
    logic                          clear_state;
  } pwf_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] drive;
    logic                          saturated;
  } pwf_out_t;

  typedef struct packed {
    logic                       start;
    logic signed [PROD_W-1:0]   mcand;
    logic signed [MPLIER_W-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic                 start;
    logic [DIVN_W-1:0]    num;
    logic [ELAPSED_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVN_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- sv/pwf_mul.sv -----
// ----------------------------------------------------------------------------
// Serial signed multiplier
// Shift-and-add over one multiplier bit per cycle; the sign bit of the
// multiplier carries negative weight, so the last step subtracts.
// ----------------------------------------------------------------------------
`default_nettype none

module pwf_mul (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  pwf_pkg::mul_req_t   req_i,
  output pwf_pkg::mul_rsp_t   rsp_o
);
  import pwf_pkg::*;

  localparam int CNT_W = $clog2(MPLIER_W);

  logic signed [PROD_W-1:0]   mcand_q, mcand_d;
  logic [MPLIER_W-1:0]        mplier_q, mplier_d;
  logic signed [PROD_W-1:0]   acc_q, acc_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic signed [PROD_W-1:0]   pp;
  logic                       last;

  assign last = (cnt_q == CNT_W'(MPLIER_W - 1));
  assign pp   = mplier_q[0] ? mcand_q : '0;

  always_comb begin
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (req_i.start) begin
      mcand_d  = req_i.mcand;
      mplier_d = req_i.mplier;
      acc_d    = '0;
      cnt_d    = '0;
      busy_d   = 1'b1;
    end else if (busy_q) begin
      acc_d    = last ? (acc_q - pp) : (acc_q + pp);
      mcand_d  = mcand_q <<< 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q + CNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

`default_nettype wire

// ----- sv/pwf_div.sv -----
// ----------------------------------------------------------------------------
// Serial unsigned divider
// Restoring division, one quotient bit per cycle, quotient shifted into the
// dividend register as the dividend bits leave it.
// ----------------------------------------------------------------------------
`default_nettype none

module pwf_div (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  pwf_pkg::div_req_t   req_i,
  output pwf_pkg::div_rsp_t   rsp_o
);
  import pwf_pkg::*;

  localparam int CNT_W = $clog2(DIVN_W);

  logic [DIVN_W-1:0]    num_q, num_d;
  logic [ELAPSED_W-1:0] rem_q, rem_d;
  logic [ELAPSED_W-1:0] den_q, den_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [ELAPSED_W:0]   trial;
  logic                 fits;

  assign trial = {rem_q, num_q[DIVN_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? ELAPSED_W'(trial - {1'b0, den_q}) : trial[ELAPSED_W-1:0];
      num_d = {num_q[DIVN_W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIVN_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = num_q;

endmodule

`default_nettype wire

// ----- sv/pid_with_feedforward.sv -----
// ----------------------------------------------------------------------------
// PID controller with setpoint feedforward
// Error, clamped integrator, derivative and four gain terms, saturated drive.
// ----------------------------------------------------------------------------
// One sample is taken at a time and yields one drive beat. The work runs
// through a serial multiplier that takes 32 steps per product and a serial
// divider that takes 25 steps, each started by a start strobe and reporting
// with a done pulse: one product for the integrator step, one divide for the
// derivative (skipped when elapsed ticks or the error change is zero), then
// four gain products. A finished result waits in an output register, and the
// next sample may be accepted while it waits.
`default_nettype none

module pid_with_feedforward (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire [pwf_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire [pwf_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  pwf_pkg::pwf_in_t                     in_data_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output pwf_pkg::pwf_out_t                    out_data_o
);
  import pwf_pkg::*;

  // Configuration registers.
  logic signed [SAMPLE_BITS-1:0] setpoint_q;
  logic signed [GAIN_W-1:0]      prop_gain_q, integ_gain_q, deriv_gain_q, ff_gain_q;
  logic [ILIM_W-1:0]             integ_limit_q;
  logic [OLIM_W-1:0]             out_limit_q;

  // Controller state.
  state_e                        state_q, state_d;
  logic signed [GAIN_W-1:0]      integ_q;
  logic signed [ERR_W-1:0]       prev_q;
  logic                          prev_vld_q;
  logic signed [ERR_W-1:0]       err_q;
  logic signed [DIFF_W-1:0]      diff_q;
  logic [ELAPSED_W-1:0]          dt_q;
  logic signed [GAIN_W-1:0]      deriv_q;
  logic signed [PROD_W-1:0]      sum_q;
  logic [1:0]                    term_q;
  logic                          out_vld_q;
  pwf_out_t                      out_q;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_fire, out_load, deriv_zero;

  pwf_mul u_mul (.clk_i, .rst_ni, .req_i(mul_req), .rsp_o(mul_rsp));
  pwf_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign deriv_zero  = (dt_q == '0) || (diff_q == '0);

  // Input-side arithmetic done at acceptance.
  logic signed [ERR_W-1:0]  err_new, prev_eff;
  logic signed [DIFF_W-1:0] diff_new;
  assign err_new  = ERR_W'(setpoint_q) - ERR_W'(in_data_i.sensor_value);
  assign prev_eff = (in_data_i.clear_state || !prev_vld_q) ? err_new : prev_q;
  assign diff_new = DIFF_W'(err_new) - DIFF_W'(prev_eff);

  // Integrator update with clamp.
  logic signed [PROD_W-1:0] integ_sum, ilim;
  assign ilim      = PROD_W'(integ_limit_q);
  assign integ_sum = PROD_W'(integ_q) + mul_rsp.prod;

  // Derivative sign and clamp.
  logic [DIFF_W-1:0]        diff_mag;
  logic [PROD_W-1:0]        quo_ext;
  logic signed [GAIN_W-1:0] quo_mag;
  assign diff_mag = diff_q[DIFF_W-1] ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);
  assign quo_ext  = PROD_W'(div_rsp.quo);
  assign quo_mag  = (quo_ext > PROD_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                       : GAIN_W'(quo_ext);

  // Product scaling, truncated toward zero.
  logic signed [PROD_W-1:0] term_g, term_d, term_val;
  assign term_g = $signed(mul_rsp.prod + (mul_rsp.prod[PROD_W-1] ?
                  PROD_W'((64'd1 << GAIN_SHIFT) - 64'd1) : '0)) >>> GAIN_SHIFT;
  assign term_d = $signed(mul_rsp.prod + (mul_rsp.prod[PROD_W-1] ?
                  PROD_W'((64'd1 << DERIV_SHIFT) - 64'd1) : '0)) >>> DERIV_SHIFT;
  assign term_val = (term_e'(term_q) == TERM_D) ? term_d : term_g;

  // Output saturation.
  logic signed [PROD_W-1:0] olim;
  logic                     sat_hi, sat_lo;
  pwf_out_t                 res;
  assign olim   = PROD_W'(out_limit_q);
  assign sat_hi = sum_q > olim;
  assign sat_lo = sum_q < -olim;
  always_comb begin
    res.saturated = sat_hi || sat_lo;
    if (sat_hi) begin
      res.drive = SAMPLE_BITS'(olim);
    end else if (sat_lo) begin
      res.drive = SAMPLE_BITS'(-olim);
    end else begin
      res.drive = SAMPLE_BITS'(sum_q);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_fire) state_d = ST_INT_GO;
      ST_INT_GO:   state_d = ST_INT_WAIT;
      ST_INT_WAIT: if (mul_rsp.done) state_d = ST_DIV_GO;
      ST_DIV_GO:   state_d = deriv_zero ? ST_TRM_GO : ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_rsp.done) state_d = ST_TRM_GO;
      ST_TRM_GO:   state_d = ST_TRM_WAIT;
      ST_TRM_WAIT: begin
        if (mul_rsp.done) state_d = (term_e'(term_q) == TERM_F) ? ST_SUM : ST_TRM_GO;
      end
      ST_SUM:      if (!out_vld_q || out_ready_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Unit requests and handshake outputs.
  always_comb begin
    in_ready_o     = (state_q == ST_IDLE);
    out_load       = (state_q == ST_SUM) && (!out_vld_q || out_ready_i);
    mul_req.start  = 1'b0;
    mul_req.mcand  = PROD_W'(err_q);
    mul_req.mplier = MPLIER_W'(dt_q);
    div_req.start  = (state_q == ST_DIV_GO) && !deriv_zero;
    div_req.num    = DIVN_W'(diff_mag) << DERIV_FRAC_BITS;
    div_req.den    = dt_q;
    case (state_q)
      ST_INT_GO: mul_req.start = 1'b1;
      ST_TRM_GO: begin
        mul_req.start = 1'b1;
        case (term_e'(term_q))
          TERM_P: begin
            mul_req.mcand  = PROD_W'(prop_gain_q);
            mul_req.mplier = MPLIER_W'(err_q);
          end
          TERM_I: begin
            mul_req.mcand  = PROD_W'(integ_gain_q);
            mul_req.mplier = MPLIER_W'(integ_q);
          end
          TERM_D: begin
            mul_req.mcand  = PROD_W'(deriv_gain_q);
            mul_req.mplier = MPLIER_W'(deriv_q);
          end
          TERM_F: begin
            mul_req.mcand  = PROD_W'(ff_gain_q);
            mul_req.mplier = MPLIER_W'(setpoint_q);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      setpoint_q    <= '0;
      prop_gain_q   <= '0;
      integ_gain_q  <= '0;
      deriv_gain_q  <= '0;
      ff_gain_q     <= '0;
      integ_limit_q <= '0;
      out_limit_q   <= '1;
      integ_q       <= '0;
      prev_q        <= '0;
      prev_vld_q    <= 1'b0;
      term_q        <= '0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SETPOINT:    setpoint_q    <= cfg_data_i[SAMPLE_BITS-1:0];
          CFG_PROP_GAIN:   prop_gain_q   <= cfg_data_i;
          CFG_INTEG_GAIN:  integ_gain_q  <= cfg_data_i;
          CFG_DERIV_GAIN:  deriv_gain_q  <= cfg_data_i;
          CFG_FF_GAIN:     ff_gain_q     <= cfg_data_i;
          CFG_INTEG_LIMIT: integ_limit_q <= cfg_data_i[ILIM_W-1:0];
          CFG_OUT_LIMIT:   out_limit_q   <= cfg_data_i[OLIM_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        if (in_data_i.clear_state) integ_q <= '0;
        prev_q     <= err_new;
        prev_vld_q <= 1'b1;
        term_q     <= '0;
      end
      if (state_q == ST_INT_WAIT && mul_rsp.done) begin
        if (integ_sum > ilim) begin
          integ_q <= GAIN_W'(ilim);
        end else if (integ_sum < -ilim) begin
          integ_q <= GAIN_W'(-ilim);
        end else begin
          integ_q <= GAIN_W'(integ_sum);
        end
      end
      if (state_q == ST_TRM_WAIT && mul_rsp.done) term_q <= term_q + 2'd1;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      err_q  <= err_new;
      diff_q <= diff_new;
      dt_q   <= in_data_i.elapsed_ticks;
      sum_q  <= '0;
    end
    if (state_q == ST_DIV_GO && deriv_zero) deriv_q <= '0;
    if (state_q == ST_DIV_WAIT && div_rsp.done) begin
      deriv_q <= diff_q[DIFF_W-1] ? -quo_mag : quo_mag;
    end
    if (state_q == ST_TRM_WAIT && mul_rsp.done) sum_q <= sum_q + term_val;
    if (out_load) out_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_fire_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_INT_GO)
    else $error("accepted sample did not start the integrator step");

  a_integ_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INT_WAIT && mul_rsp.done) |=>
      (PROD_W'(integ_q) <= ilim && PROD_W'(integ_q) >= -ilim))
    else $error("integrator left its clamp");

  a_drive_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (PROD_W'(out_q.drive) <= olim && PROD_W'(out_q.drive) >= -olim))
    else $error("drive beyond out_limit");

endmodule

`default_nettype wire
